// ===== rtl/core/rci_pkg.sv =====
package rci_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int MUL_LAT   = 5;
  localparam int SQ_W      = 65;
  localparam int RAD_W     = 2 * SQ_W;
  localparam int DIV_W     = 82;
  localparam int A_W       = 64;
  localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_RADIUS   = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] distance;
  } res_t;

endpackage

// ===== rtl/core/rci_if.sv =====
interface rci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] dir_x;
  logic signed [31:0] dir_y;
  logic signed [31:0] dir_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    output ready
  );
endinterface

interface rci_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [30:0] hit_distance;

  modport source (output valid, hit, hit_distance, input ready);
  modport sink (input valid, hit, hit_distance, output ready);
endinterface

// ===== rtl/core/rci_delay.sv =====
module rci_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int k = 1; k < N; k++) begin
        sh_r[k] <= sh_r[k-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

// ===== rtl/core/rci_mul.sv =====
module rci_mul #(
  parameter int W = 67
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a_i,
  input  logic signed [W-1:0]   b_i,
  output logic signed [2*W-1:0] p_o
);

  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int PW = 2 * W;

  logic [W-1:0]    ma_r, mb_r;
  logic            neg1_r, neg2_r, neg3_r, neg4_r;
  logic [2*H-1:0]  ll_r, ll3_r;
  logic [W-1:0]    lh_r, hl_r;
  logic [2*L-1:0]  hh_r, hh3_r;
  logic [W:0]      mid_r;
  logic [PW-1:0]   prod_r, p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= a_i[W-1] ? W'(-a_i) : W'(a_i);
      mb_r   <= b_i[W-1] ? W'(-b_i) : W'(b_i);
      neg1_r <= a_i[W-1] ^ b_i[W-1];

      ll_r   <= (2*H)'(ma_r[H-1:0]) * (2*H)'(mb_r[H-1:0]);
      lh_r   <= W'(ma_r[H-1:0]) * W'(mb_r[W-1:H]);
      hl_r   <= W'(ma_r[W-1:H]) * W'(mb_r[H-1:0]);
      hh_r   <= (2*L)'(ma_r[W-1:H]) * (2*L)'(mb_r[W-1:H]);
      neg2_r <= neg1_r;

      mid_r  <= (W+1)'(lh_r) + (W+1)'(hl_r);
      ll3_r  <= ll_r;
      hh3_r  <= hh_r;
      neg3_r <= neg2_r;

      prod_r <= (PW'(hh3_r) << (2*H)) + (PW'(mid_r) << H) + PW'(ll3_r);
      neg4_r <= neg3_r;

      p_r    <= neg4_r ? PW'(-prod_r) : prod_r;
    end
  end

  assign p_o = $signed(p_r);

endmodule

// ===== rtl/core/rci_sqrt_cell.sv =====
module rci_sqrt_cell
  import rci_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [RAD_W-1:0] rem_i,
  input  logic [SQ_W-1:0]  root_i,
  output logic [RAD_W-1:0] rem_o,
  output logic [SQ_W-1:0]  root_o
);

  localparam int TW = RAD_W + 2;

  logic [TW-1:0]    trial;
  logic             ge;
  logic [RAD_W-1:0] rem_nxt, rem_r;
  logic [SQ_W-1:0]  root_nxt, root_r;

  always_comb begin
    trial    = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    ge       = TW'(rem_i) >= trial;
    rem_nxt  = ge ? RAD_W'(TW'(rem_i) - trial) : rem_i;
    root_nxt = ge ? (root_i | (SQ_W'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// ===== rtl/core/rci_div_cell.sv =====
module rci_div_cell
  import rci_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic             clk,
  input  logic             en,
  input  logic [DIV_W-1:0] rem_i,
  input  logic [A_W-1:0]   dvs_i,
  input  logic [DIV_W-1:0] quo_i,
  output logic [DIV_W-1:0] rem_o,
  output logic [A_W-1:0]   dvs_o,
  output logic [DIV_W-1:0] quo_o
);

  logic             ge;
  logic [DIV_W-1:0] rem_nxt, rem_r, quo_nxt, quo_r;
  logic [A_W-1:0]   dvs_r;

  always_comb begin
    ge      = (rem_i >> BIT) >= DIV_W'(dvs_i);
    rem_nxt = ge ? (rem_i - (DIV_W'(dvs_i) << BIT)) : rem_i;
    quo_nxt = ge ? (quo_i | (DIV_W'(1) << BIT)) : quo_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      dvs_r <= dvs_i;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dvs_o = dvs_r;

endmodule

// ===== rtl/core/ray_cylinder_intersect.sv =====
// Throughput: one item per cycle while the output buffer is not full; the depth
// is set by the 65-cell square root row and the two 82-cell divider rows, each
// cell resolving one result bit.
// A two-entry output buffer lets the pipeline run on while one result waits.
// Synchronous active-low reset empties the pipeline and restores the
// configuration registers to their defaults.
module ray_cylinder_intersect
  import rci_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rci_in_if.sink               in_ray,
  rci_out_if.source            out_hit,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int NST = 3 + MUL_LAT + 1 + SQ_W + 1 + DIV_W + 3;

  typedef struct packed {
    logic [A_W-1:0]     a;
    logic signed [65:0] b;
    logic signed [31:0] dy;
    logic signed [32:0] qy;
  } sb_mul_t;

  typedef struct packed {
    logic               live;
    logic [A_W-1:0]     a;
    logic signed [65:0] b;
    logic signed [31:0] dy;
    logic signed [32:0] qy;
  } sb_sq_t;

  typedef struct packed {
    logic               live;
    logic               ok1;
    logic               ok2;
    logic signed [31:0] dy;
    logic signed [32:0] qy;
  } sb_div_t;

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        rad_r, ht_r;
  logic [NST-1:0]     vld_r, vld_nxt;
  logic [1:0]         cnt_r;
  res_t               slot0_r, slot1_r;
  logic               en, in_fire, push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= 31'd65536;
      ht_r  <= 31'd131072;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: cx_r  <= $signed(cfg_data);
        CFG_CENTER_Y: cy_r  <= $signed(cfg_data);
        CFG_CENTER_Z: cz_r  <= $signed(cfg_data);
        CFG_RADIUS:   rad_r <= cfg_data[30:0];
        CFG_HEIGHT:   ht_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign en            = (cnt_r != 2'd2);
  assign in_ray.ready  = en;
  assign in_fire       = in_ray.valid & en;
  assign vld_nxt       = {vld_r[NST-2:0], in_fire};
  assign push          = en & vld_r[NST-1];
  assign pop           = out_hit.valid & out_hit.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  logic signed [32:0] s1_px_r, s1_pz_r, s1_qy_r;
  logic signed [31:0] s1_dx_r, s1_dz_r, s1_dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r <= 33'(in_ray.origin_x) - 33'(cx_r);
      s1_pz_r <= 33'(in_ray.origin_z) - 33'(cz_r);
      s1_qy_r <= 33'(in_ray.origin_y) - 33'(cy_r);
      s1_dx_r <= in_ray.dir_x;
      s1_dz_r <= in_ray.dir_z;
      s1_dy_r <= in_ray.dir_y;
    end
  end

  logic signed [63:0] dx64, dz64;
  logic signed [64:0] dx65, dz65, px65, pz65;
  logic signed [65:0] px66, pz66;
  logic [61:0]        r62;
  logic signed [63:0] s2_dxdx_r, s2_dzdz_r;
  logic signed [64:0] s2_dxpx_r, s2_dzpz_r;
  logic signed [65:0] s2_pxpx_r, s2_pzpz_r;
  logic [61:0]        s2_rr_r;
  logic signed [31:0] s2_dy_r;
  logic signed [32:0] s2_qy_r;

  assign dx64 = 64'(s1_dx_r);
  assign dz64 = 64'(s1_dz_r);
  assign dx65 = 65'(s1_dx_r);
  assign dz65 = 65'(s1_dz_r);
  assign px65 = 65'(s1_px_r);
  assign pz65 = 65'(s1_pz_r);
  assign px66 = 66'(s1_px_r);
  assign pz66 = 66'(s1_pz_r);
  assign r62  = 62'(rad_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dxdx_r <= dx64 * dx64;
      s2_dzdz_r <= dz64 * dz64;
      s2_dxpx_r <= dx65 * px65;
      s2_dzpz_r <= dz65 * pz65;
      s2_pxpx_r <= px66 * px66;
      s2_pzpz_r <= pz66 * pz66;
      s2_rr_r   <= r62 * r62;
      s2_dy_r   <= s1_dy_r;
      s2_qy_r   <= s1_qy_r;
    end
  end

  logic [A_W-1:0]     s3_a_r;
  logic signed [65:0] s3_b_r;
  logic signed [66:0] s3_c_r;
  logic signed [31:0] s3_dy_r;
  logic signed [32:0] s3_qy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_r  <= $unsigned(s2_dxdx_r + s2_dzdz_r);
      s3_b_r  <= 66'(s2_dxpx_r) + 66'(s2_dzpz_r);
      s3_c_r  <= 67'(s2_pxpx_r) + 67'(s2_pzpz_r) - $signed({5'b0, s2_rr_r});
      s3_dy_r <= s2_dy_r;
      s3_qy_r <= s2_qy_r;
    end
  end

  logic signed [66:0]  bb_in, ac_in;
  logic signed [133:0] bb, ac;
  sb_mul_t             mul_sb_d, mul_sb_q;

  assign bb_in = 67'(s3_b_r);
  assign ac_in = $signed({3'b0, s3_a_r});

  rci_mul #(.W(67)) u_mul_bb (
    .clk (clk), .en (en), .a_i (bb_in), .b_i (bb_in), .p_o (bb)
  );

  rci_mul #(.W(67)) u_mul_ac (
    .clk (clk), .en (en), .a_i (ac_in), .b_i (s3_c_r), .p_o (ac)
  );

  assign mul_sb_d = '{a: s3_a_r, b: s3_b_r, dy: s3_dy_r, qy: s3_qy_r};

  rci_delay #(.W($bits(sb_mul_t)), .N(MUL_LAT)) u_dly_mul (
    .clk (clk), .en (en), .d (mul_sb_d), .q (mul_sb_q)
  );

  logic signed [134:0] disc;
  logic                dpos;
  logic [RAD_W-1:0]    s4_rad_r;
  sb_sq_t              s4_sb_r, sq_sb_q;

  assign disc = 135'(bb) - 135'(ac);
  assign dpos = !disc[134] && (disc != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_rad_r <= dpos ? disc[RAD_W-1:0] : '0;
      s4_sb_r  <= '{live: dpos && (mul_sb_q.a != '0), a: mul_sb_q.a, b: mul_sb_q.b,
                    dy: mul_sb_q.dy, qy: mul_sb_q.qy};
    end
  end

  logic [RAD_W-1:0] sq_rem  [SQ_W+1];
  logic [SQ_W-1:0]  sq_root [SQ_W+1];

  assign sq_rem[0]  = s4_rad_r;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQ_W; k++) begin : g_sq
    rci_sqrt_cell #(.BIT(SQ_W - 1 - k)) u_cell (
      .clk    (clk),
      .en     (en),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  rci_delay #(.W($bits(sb_sq_t)), .N(SQ_W)) u_dly_sq (
    .clk (clk), .en (en), .d (s4_sb_r), .q (sq_sb_q)
  );

  logic signed [67:0] n1, n2;
  logic [DIV_W-1:0]   s5_num1_r, s5_num2_r;
  logic [A_W-1:0]     s5_a_r;
  sb_div_t            s5_sb_r, dv_sb_q;

  assign n1 = -68'(sq_sb_q.b) - $signed({3'b0, sq_root[SQ_W]});
  assign n2 = -68'(sq_sb_q.b) + $signed({3'b0, sq_root[SQ_W]});

  always_ff @(posedge clk) begin
    if (en) begin
      s5_num1_r <= n1[67] ? '0 : {n1[65:0], 16'b0};
      s5_num2_r <= n2[67] ? '0 : {n2[65:0], 16'b0};
      s5_a_r    <= sq_sb_q.a;
      s5_sb_r   <= '{live: sq_sb_q.live, ok1: !n1[67], ok2: !n2[67],
                     dy: sq_sb_q.dy, qy: sq_sb_q.qy};
    end
  end

  logic [DIV_W-1:0] dv1_rem [DIV_W+1];
  logic [DIV_W-1:0] dv1_quo [DIV_W+1];
  logic [A_W-1:0]   dv1_dvs [DIV_W+1];
  logic [DIV_W-1:0] dv2_rem [DIV_W+1];
  logic [DIV_W-1:0] dv2_quo [DIV_W+1];
  logic [A_W-1:0]   dv2_dvs [DIV_W+1];

  assign dv1_rem[0] = s5_num1_r;
  assign dv1_quo[0] = '0;
  assign dv1_dvs[0] = s5_a_r;
  assign dv2_rem[0] = s5_num2_r;
  assign dv2_quo[0] = '0;
  assign dv2_dvs[0] = s5_a_r;

  for (genvar k = 0; k < DIV_W; k++) begin : g_div
    rci_div_cell #(.BIT(DIV_W - 1 - k)) u_cell1 (
      .clk   (clk),
      .en    (en),
      .rem_i (dv1_rem[k]),
      .dvs_i (dv1_dvs[k]),
      .quo_i (dv1_quo[k]),
      .rem_o (dv1_rem[k+1]),
      .dvs_o (dv1_dvs[k+1]),
      .quo_o (dv1_quo[k+1])
    );
    rci_div_cell #(.BIT(DIV_W - 1 - k)) u_cell2 (
      .clk   (clk),
      .en    (en),
      .rem_i (dv2_rem[k]),
      .dvs_i (dv2_dvs[k]),
      .quo_i (dv2_quo[k]),
      .rem_o (dv2_rem[k+1]),
      .dvs_o (dv2_dvs[k+1]),
      .quo_o (dv2_quo[k+1])
    );
  end

  rci_delay #(.W($bits(sb_div_t)), .N(DIV_W)) u_dly_div (
    .clk (clk), .en (en), .d (s5_sb_r), .q (dv_sb_q)
  );

  logic [DIV_W-1:0]   q1, q2;
  logic signed [57:0] q1l, q1h, q2l, q2h, dy58;
  logic               dynz;
  logic signed [57:0] v1_pl1_r, v1_ph1_r, v1_pl2_r, v1_ph2_r;
  logic [DIV_W-1:0]   v1_q1_r, v1_q2_r;
  logic               v1_ok1_r, v1_ok2_r, v1_live_r;
  logic signed [32:0] v1_qy_r;

  assign q1   = dv1_quo[DIV_W];
  assign q2   = dv2_quo[DIV_W];
  assign q1l  = $signed({33'b0, q1[24:0]});
  assign q1h  = $signed({33'b0, q1[49:25]});
  assign q2l  = $signed({33'b0, q2[24:0]});
  assign q2h  = $signed({33'b0, q2[49:25]});
  assign dy58 = 58'(dv_sb_q.dy);
  assign dynz = (dv_sb_q.dy != '0);

  // A root of 2^50 or more with a moving y lands far outside any height.
  always_ff @(posedge clk) begin
    if (en) begin
      v1_pl1_r  <= q1l * dy58;
      v1_ph1_r  <= q1h * dy58;
      v1_pl2_r  <= q2l * dy58;
      v1_ph2_r  <= q2h * dy58;
      v1_q1_r   <= q1;
      v1_q2_r   <= q2;
      v1_ok1_r  <= dv_sb_q.ok1 && !(dynz && (q1[DIV_W-1:50] != '0));
      v1_ok2_r  <= dv_sb_q.ok2 && !(dynz && (q2[DIV_W-1:50] != '0));
      v1_live_r <= dv_sb_q.live;
      v1_qy_r   <= dv_sb_q.qy;
    end
  end

  logic signed [84:0] y1, y2, qy85;
  logic signed [85:0] v2_y1_r, v2_y2_r;
  logic [DIV_W-1:0]   v2_q1_r, v2_q2_r;
  logic               v2_ok1_r, v2_ok2_r, v2_live_r;

  assign qy85 = 85'(v1_qy_r) <<< 16;
  assign y1   = (85'(v1_ph1_r) <<< 25) + 85'(v1_pl1_r) + qy85;
  assign y2   = (85'(v1_ph2_r) <<< 25) + 85'(v1_pl2_r) + qy85;

  always_ff @(posedge clk) begin
    if (en) begin
      v2_y1_r   <= {y1, 1'b0};
      v2_y2_r   <= {y2, 1'b0};
      v2_q1_r   <= v1_q1_r;
      v2_q2_r   <= v1_q2_r;
      v2_ok1_r  <= v1_ok1_r;
      v2_ok2_r  <= v1_ok2_r;
      v2_live_r <= v1_live_r;
    end
  end

  logic signed [85:0] hh;
  logic               in1, in2, hit;
  logic [DIV_W-1:0]   t_sel;
  res_t               v3_res_nxt, v3_res_r;

  assign hh  = $signed({39'b0, ht_r, 16'b0});
  assign in1 = v2_ok1_r && (v2_y1_r <= hh) && (v2_y1_r >= -hh);
  assign in2 = v2_ok2_r && (v2_y2_r <= hh) && (v2_y2_r >= -hh);
  assign hit = v2_live_r && (in1 || in2);

  always_comb begin
    t_sel               = in1 ? v2_q1_r : v2_q2_r;
    v3_res_nxt.hit      = hit;
    v3_res_nxt.distance = '0;
    if (hit) begin
      v3_res_nxt.distance = (t_sel[DIV_W-1:31] != '0) ? SAT31 : t_sel[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3_res_r <= v3_res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= v3_res_r;
      end else begin
        slot1_r <= v3_res_r;
      end
    end else if (pop && !push) begin
      slot0_r <= slot1_r;
    end else if (push && pop) begin
      slot0_r <= v3_res_r;
    end
  end

  assign out_hit.valid        = (cnt_r != 2'd0);
  assign out_hit.hit          = slot0_r.hit;
  assign out_hit.hit_distance = slot0_r.distance;

endmodule

// ===== rtl/core/rci_checker.sv =====
module rci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [30:0] hit_distance
);

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !hit |-> hit_distance == 31'd0)
    else $error("miss carries a non-zero distance");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input held off with no result waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(hit_distance))
    else $error("waiting result changed");

  a_in_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind ray_cylinder_intersect rci_checker u_rci_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ray.ready),
  .out_valid    (out_hit.valid),
  .out_ready    (out_hit.ready),
  .hit          (out_hit.hit),
  .hit_distance (out_hit.hit_distance)
);

// ===== tb/tb_ray_cylinder_intersect.sv =====
`timescale 1ns / 100ps

module tb_ray_cylinder_intersect;
  import rci_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  typedef logic signed [255:0] wide_t;

  class hit_scoreboard;
    wide_t cx, cy, cz, rad, hgt;
    res_t  pending[$];
    int    errors;

    function new();
      cx = 0;
      cy = 0;
      cz = 0;
      rad = 65536;
      hgt = 131072;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      logic signed [31:0] sdata;
      sdata = data;
      case (idx)
        CFG_CENTER_X: cx = sdata;
        CFG_CENTER_Y: cy = sdata;
        CFG_CENTER_Z: cz = sdata;
        CFG_RADIUS: begin
          rad = 0;
          rad[30:0] = data[30:0];
        end
        CFG_HEIGHT: begin
          hgt = 0;
          hgt[30:0] = data[30:0];
        end
        default: ;
      endcase
    endfunction

    function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                           logic signed [31:0] oz, logic signed [31:0] dx,
                           logic signed [31:0] dy, logic signed [31:0] dz);
      wide_t px, pz, wdx, wdy, wdz, a, b, c, d, s, cand, nb, qy, hh, n, t, q;
      res_t  r;
      bit    found;
      wdx = dx;
      wdy = dy;
      wdz = dz;
      px = ox;
      px = px - cx;
      pz = oz;
      pz = pz - cz;
      r = '0;
      found = 0;
      t = 0;
      a = wdx * wdx + wdz * wdz;
      b = wdx * px + wdz * pz;
      c = px * px + pz * pz - rad * rad;
      d = b * b - a * c;
      if (a != 0 && d > 0) begin
        s = 0;
        for (int i = 69; i >= 0; i--) begin
          cand = s | (wide_t'(1) << i);
          if (cand * cand <= d) s = cand;
        end
        nb = -b;
        qy = oy;
        qy = (qy - cy) * 65536;
        hh = hgt * 65536;
        for (int k = 0; k < 2 && !found; k++) begin
          n = (k == 0) ? nb - s : nb + s;
          if (n >= 0) begin
            t = (n * 65536) / a;
            q = 2 * (t * wdy + qy);
            if (q <= hh && q >= -hh) found = 1;
          end
        end
      end
      if (found) begin
        r.hit = 1'b1;
        r.distance = (t > wide_t'(SAT31)) ? SAT31 : t[30:0];
      end
      pending.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", what, got, want);
      errors++;
    endtask

    task check_result(logic hit, logic [30:0] distance);
      res_t e;
      if (pending.size() == 0) begin
        report("unexpected result", {hit, distance}, 32'h0);
      end else begin
        e = pending.pop_front();
        if (hit !== e.hit) report("hit", hit, e.hit);
        if (distance !== e.distance) report("hit_distance", distance, e.distance);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rci_in_if  in_ray();
  rci_out_if out_hit();

  hit_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_count = 0;

  always #1 clk = ~clk;

  ray_cylinder_intersect dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ray   (in_ray),
    .out_hit  (out_hit),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    in_ray.valid = 1'b0;
    in_ray.origin_x = '0;
    in_ray.origin_y = '0;
    in_ray.origin_z = '0;
    in_ray.dir_x = '0;
    in_ray.dir_y = '0;
    in_ray.dir_z = '0;
    out_hit.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ray.valid && in_ray.ready) begin
        sb.note_ray(in_ray.origin_x, in_ray.origin_y, in_ray.origin_z,
                    in_ray.dir_x, in_ray.dir_y, in_ray.dir_z);
      end
      if (out_hit.valid && out_hit.ready) sb.check_result(out_hit.hit, out_hit.hit_distance);
      if ((in_ray.valid && in_ray.ready) || (out_hit.valid && out_hit.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout with %0d results outstanding", sb.pending.size());
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rx_count == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_count = $urandom_range(16, 96);
    end
    rx_count--;
    case (rx_mode)
      0: out_hit.ready <= 1'b1;
      1: out_hit.ready <= $urandom_range(0, 1);
      default: out_hit.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    if (burst_left == 0) begin
      @(negedge clk);
      in_ray.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    in_ray.valid = 1'b1;
    in_ray.origin_x = ox;
    in_ray.origin_y = oy;
    in_ray.origin_z = oz;
    in_ray.dir_x = dx;
    in_ray.dir_y = dy;
    in_ray.dir_z = dz;
    @(posedge clk);
    while (!in_ray.ready) @(posedge clk);
  endtask

  task end_burst();
    @(negedge clk);
    in_ray.valid = 1'b0;
    burst_left = 0;
  endtask

  task configure(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                 logic [31:0] r, logic [31:0] h);
    end_burst();
    wait_drained();
    write_reg(CFG_CENTER_X, x);
    write_reg(CFG_CENTER_Y, y);
    write_reg(CFG_CENTER_Z, z);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_HEIGHT, h);
  endtask

  function automatic logic [31:0] near_val(logic [31:0] base, int span);
    return base + $urandom_range(0, 2 * span) - span;
  endfunction

  task random_rays(int count);
    logic [31:0] sx;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        end_burst();
        wait_drained();
      end
      if ($urandom_range(0, 9) < 8) begin
        sx = sb.rad[31:0] * $urandom_range(1, 4);
        if (sx == 0 || sx > 32'h0100_0000) sx = 32'h0008_0000;
        send_ray(near_val(sb.cx[31:0], sx), near_val(sb.cy[31:0], sb.hgt[31:0] + 1),
                 near_val(sb.cz[31:0], sx), near_val(0, $urandom_range(1, 32'h0004_0000)),
                 near_val(0, $urandom_range(1, 32'h0000_8000)),
                 near_val(0, $urandom_range(1, 32'h0004_0000)));
      end else begin
        send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_ray(32'hFFFC_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(0, 0, 0, 0, 32'h0001_0000, 0);
    send_ray(32'hFFFC_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
    send_ray(32'hFFFC_0000, 0, 32'h0003_0000, 32'h0001_0000, 0, 0);
    send_ray(32'h0004_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(0, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(32'hFFFC_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    send_ray(32'hFFFC_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0000_8000, 0);
    send_ray(32'hFFFC_0000, 0, 0, 32'h0000_0001, 0, 0);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_ray(32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h8000_0000);
    send_ray(0, 0, 32'hFFFB_0000, 0, 0, 32'h0000_4000);

    configure(0, 0, 0, 32'h0002_0000, 0);
    send_ray(32'hFFFC_0000, 0, 0, 32'h0001_0000, 0, 0);
    send_ray(32'hFFFC_0000, 32'h0000_0001, 0, 32'h0001_0000, 0, 0);
    send_ray(32'hFFFC_0000, 32'hFFFE_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
    end_burst();
    wait_drained();
    write_reg(3'd5, 32'hFFFF_FFFF);
    write_reg(3'd7, 32'h1234_5678);
    send_ray(32'hFFFC_0000, 0, 0, 32'h0001_0000, 0, 0);

    configure(0, 0, 0, 32'h0001_0000, 32'h0002_0000);
    random_rays(150);
    configure($urandom, $urandom, $urandom, $urandom_range(1, 32'h0010_0000),
              $urandom_range(0, 32'h0010_0000));
    random_rays(150);
    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    random_rays(150);
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
    random_rays(120);
    configure(32'h0003_8000, 32'hFFFF_0000, 32'hFFFD_0000, 32'h0000_0001, 32'h8000_0000);
    random_rays(100);
    configure($urandom, $urandom, $urandom, $urandom, $urandom);
    random_rays(100);
    configure(32'hFFF0_0000, 32'h0000_4000, 32'h0010_0000, 32'h0004_0000, 32'h0000_0000);
    random_rays(100);

    end_burst();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ray_cylinder_intersect.f =====
rtl/core/rci_pkg.sv
rtl/core/rci_if.sv
rtl/core/rci_delay.sv
rtl/core/rci_mul.sv
rtl/core/rci_sqrt_cell.sv
rtl/core/rci_div_cell.sv
rtl/core/ray_cylinder_intersect.sv
rtl/core/rci_checker.sv
tb/tb_ray_cylinder_intersect.sv
